### design/wbmp_pkg.sv
// Shared package for the WBMP stream decoder.
// Holds the job record passed from parser to emitter, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package wbmp_pkg;

    // Default dimension width of the parser
    localparam int DIM_BITS_DEF = 16;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SET_PIXEL   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLEAR_PIXEL = 1'b1;

    // Configuration reset values
    localparam logic [7:0] SET_PIXEL_RESET   = 8'hFF;
    localparam logic [7:0] CLEAR_PIXEL_RESET = 8'h00;

    // Result kinds
    localparam logic KIND_GEOMETRY = 1'b0;
    localparam logic KIND_PIXEL    = 1'b1;

    // One unit of output work: a geometry report or one image byte
    typedef struct packed {
        logic        kind;
        logic [7:0]  bits;
        logic [15:0] col;
        logic [15:0] row;
        logic [15:0] width;
        logic [15:0] height;
        logic        type_err;
        logic [2:0]  cnt_m1;
        logic        eor_end;
        logic        eoi_end;
    } job_t;

endpackage

### design/wbmp_parse.sv
// Byte parser of the WBMP stream decoder: header, extension headers, geometry, row tracking.
// Turns each accepted byte into at most one job for the emitter.
// Depends on wbmp_pkg.
`timescale 1ns / 1ps

module wbmp_parse #(
    parameter int DIM_BITS = wbmp_pkg::DIM_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      byte_in,
    input  logic            start_of_file,
    input  logic            job_free,
    output logic            job_load,
    output wbmp_pkg::job_t  job
);

    typedef enum logic [3:0] {
        PH_TYPE,
        PH_FIX,
        PH_EXT,
        PH_SKIP_CONT,
        PH_SKIP_N,
        PH_WIDTH,
        PH_HEIGHT,
        PH_PIXELS,
        PH_DONE
    } phase_t;

    phase_t              phase_reg, phase_next, phase_c;
    logic [DIM_BITS-1:0] acc_reg, acc_next, acc_c;
    logic [4:0]          skip_reg, skip_next, skip_c;
    logic [DIM_BITS-1:0] width_reg, width_next, width_c;
    logic [DIM_BITS-1:0] height_reg, height_next, height_c;
    logic [DIM_BITS-1:0] col_reg, col_next, col_c;
    logic [DIM_BITS-1:0] row_reg, row_next, row_c;
    logic                type_bad_reg, type_bad_next, type_bad_c;
    logic                more_reg, more_next, more_c;

    logic                accept;
    logic [DIM_BITS+6:0] acc_wide;
    logic [DIM_BITS-1:0] acc_sat;
    logic [DIM_BITS-1:0] rem;
    logic                rem_ge8;
    logic                rem_le8;
    logic [DIM_BITS-1:0] step;
    logic [DIM_BITS:0]   row_inc;
    logic                last_row;
    logic [4:0]          skip_sum;
    logic                empty;

    // Accept a byte whenever the job slot can take its work
    assign accept   = in_valid && job_free;
    assign in_stall = !job_free;

    // Start of file restarts the parser for this very byte
    assign phase_c    = start_of_file ? PH_TYPE : phase_reg;
    assign acc_c      = start_of_file ? '0 : acc_reg;
    assign skip_c     = start_of_file ? '0 : skip_reg;
    assign width_c    = start_of_file ? '0 : width_reg;
    assign height_c   = start_of_file ? '0 : height_reg;
    assign col_c      = start_of_file ? '0 : col_reg;
    assign row_c      = start_of_file ? '0 : row_reg;
    assign type_bad_c = start_of_file ? 1'b0 : type_bad_reg;
    assign more_c     = start_of_file ? 1'b0 : more_reg;

    // Shift in seven bits and saturate the multi-byte integer
    assign acc_wide = {acc_c, byte_in[6:0]};
    assign acc_sat  = (|acc_wide[DIM_BITS+6:DIM_BITS]) ? '1 : acc_wide[DIM_BITS-1:0];

    // Pixels left in the current row
    assign rem      = width_c - col_c;
    assign rem_ge8  = rem >= DIM_BITS'(8);
    assign rem_le8  = rem <= DIM_BITS'(8);
    assign step     = rem_ge8 ? DIM_BITS'(8) : rem;
    assign row_inc  = {1'b0, row_c} + (DIM_BITS+1)'(1);
    assign last_row = row_inc == {1'b0, height_c};

    // Extension header skip length
    assign skip_sum = {2'b00, byte_in[6:4]} + {1'b0, byte_in[3:0]};
    assign empty    = (width_c == '0) || (acc_sat == '0);

    // Next parser state and job for the accepted byte
    always_comb
    begin
        phase_next    = phase_c;
        acc_next      = acc_c;
        skip_next     = skip_c;
        width_next    = width_c;
        height_next   = height_c;
        col_next      = col_c;
        row_next      = row_c;
        type_bad_next = type_bad_c;
        more_next     = more_c;
        job_load      = 1'b0;
        job           = '0;

        unique case (phase_c)
            PH_TYPE:
            begin
                if (byte_in[6:0] != 7'd0)
                    type_bad_next = 1'b1;
                if (!byte_in[7])
                    phase_next = PH_FIX;
            end
            PH_FIX:
            begin
                phase_next = byte_in[7] ? PH_EXT : PH_WIDTH;
            end
            PH_EXT:
            begin
                more_next = byte_in[7];
                if (byte_in[6:5] == 2'b00)
                    phase_next = PH_SKIP_CONT;
                else if (byte_in[6:5] == 2'b11)
                begin
                    skip_next = skip_sum;
                    if (skip_sum != 5'd0)
                        phase_next = PH_SKIP_N;
                    else
                        phase_next = byte_in[7] ? PH_EXT : PH_WIDTH;
                end
                else
                    phase_next = byte_in[7] ? PH_EXT : PH_WIDTH;
            end
            PH_SKIP_CONT:
            begin
                if (!byte_in[7])
                    phase_next = more_c ? PH_EXT : PH_WIDTH;
            end
            PH_SKIP_N:
            begin
                skip_next = skip_c - 5'd1;
                if (skip_c == 5'd1)
                    phase_next = more_c ? PH_EXT : PH_WIDTH;
            end
            PH_WIDTH:
            begin
                acc_next = acc_sat;
                if (!byte_in[7])
                begin
                    width_next = acc_sat;
                    acc_next   = '0;
                    phase_next = PH_HEIGHT;
                end
            end
            PH_HEIGHT:
            begin
                acc_next = acc_sat;
                if (!byte_in[7])
                begin
                    height_next  = acc_sat;
                    acc_next     = '0;
                    col_next     = '0;
                    row_next     = '0;
                    phase_next   = empty ? PH_DONE : PH_PIXELS;
                    job_load     = accept;
                    job.kind     = wbmp_pkg::KIND_GEOMETRY;
                    job.width    = 16'(width_c);
                    job.height   = 16'(acc_sat);
                    job.type_err = type_bad_c;
                    job.cnt_m1   = 3'd0;
                    job.eoi_end  = empty;
                end
            end
            PH_PIXELS:
            begin
                job_load     = accept;
                job.kind     = wbmp_pkg::KIND_PIXEL;
                job.bits     = byte_in;
                job.col      = 16'(col_c);
                job.row      = 16'(row_c);
                job.width    = 16'(width_c);
                job.height   = 16'(height_c);
                job.type_err = type_bad_c;
                job.cnt_m1   = rem_ge8 ? 3'd7 : 3'(rem - DIM_BITS'(1));
                job.eor_end  = rem_le8;
                job.eoi_end  = rem_le8 && last_row;
                if (rem_le8)
                begin
                    col_next = '0;
                    row_next = row_inc[DIM_BITS-1:0];
                    if (last_row)
                        phase_next = PH_DONE;
                end
                else
                    col_next = col_c + step;
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    // Hold parser state; advance on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TYPE;
            acc_reg      <= '0;
            skip_reg     <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            type_bad_reg <= 1'b0;
            more_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            skip_reg     <= skip_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            type_bad_reg <= type_bad_next;
            more_reg     <= more_next;
        end
    end

endmodule

### design/wbmp_emit.sv
// Result emitter of the WBMP stream decoder: job register, pixel stepping, output register.
// Also holds the set and clear pixel value registers.
// Depends on wbmp_pkg.
`timescale 1ns / 1ps

module wbmp_emit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [wbmp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [7:0]                           cfg_data,
    input  logic                                 job_load,
    input  wbmp_pkg::job_t                       job,
    output logic                                 job_free,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 result_kind,
    output logic [7:0]                           pixel_value,
    output logic [15:0]                          pixel_column,
    output logic [15:0]                          pixel_row,
    output logic [15:0]                          image_width,
    output logic [15:0]                          image_height,
    output logic                                 type_error,
    output logic                                 last_of_run,
    output logic                                 end_of_row,
    output logic                                 end_of_image
);

    wbmp_pkg::job_t job_reg;
    logic           job_valid_reg;
    logic [2:0]     k_reg;
    logic [7:0]     set_val_reg;
    logic [7:0]     clear_val_reg;

    logic           out_valid_reg;
    logic           kind_reg;
    logic [7:0]     value_reg;
    logic [15:0]    col_reg;
    logic [15:0]    row_reg;
    logic [15:0]    width_reg;
    logic [15:0]    height_reg;
    logic           type_err_reg;
    logic           last_reg;
    logic           eor_reg;
    logic           eoi_reg;

    logic           advance;
    logic           last;
    logic           pix_bit;
    logic [7:0]     value_next;

    // Output register moves when empty or taken
    assign advance  = !out_valid_reg || !out_stall;
    assign last     = k_reg == job_reg.cnt_m1;
    assign job_free = !job_valid_reg || (advance && last);

    // Pick the pixel bit, MSB first
    assign pix_bit = job_reg.bits[~k_reg];

    always_comb
    begin
        case (job_reg.kind)
            wbmp_pkg::KIND_PIXEL:
                value_next = pix_bit ? set_val_reg : clear_val_reg;
            default:
                value_next = 8'd0;
        endcase
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_val_reg   <= wbmp_pkg::SET_PIXEL_RESET;
            clear_val_reg <= wbmp_pkg::CLEAR_PIXEL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wbmp_pkg::CFG_SET_PIXEL:   set_val_reg   <= cfg_data;
                wbmp_pkg::CFG_CLEAR_PIXEL: clear_val_reg <= cfg_data;
            endcase
        end
    end

    // Hold the current job and step through its pixels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            k_reg         <= 3'd0;
        end
        else if (job_load)
        begin
            job_valid_reg <= 1'b1;
            k_reg         <= 3'd0;
        end
        else if (advance && job_valid_reg)
        begin
            if (last)
                job_valid_reg <= 1'b0;
            else
                k_reg <= k_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
            job_reg <= job;
    end

    // Load the output register with one result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= job_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && job_valid_reg)
        begin
            kind_reg     <= job_reg.kind;
            value_reg    <= value_next;
            col_reg      <= job_reg.col + 16'(k_reg);
            row_reg      <= job_reg.row;
            width_reg    <= job_reg.width;
            height_reg   <= job_reg.height;
            type_err_reg <= job_reg.type_err;
            last_reg     <= last;
            eor_reg      <= last && job_reg.eor_end;
            eoi_reg      <= last && job_reg.eoi_end;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign pixel_value  = value_reg;
    assign pixel_column = col_reg;
    assign pixel_row    = row_reg;
    assign image_width  = width_reg;
    assign image_height = height_reg;
    assign type_error   = type_err_reg;
    assign last_of_run  = last_reg;
    assign end_of_row   = eor_reg;
    assign end_of_image = eoi_reg;

    // Step index never runs past the job's pixel count
    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (k_reg <= job_reg.cnt_m1))
        else $error("emitter step index past job count");

    // A geometry job yields exactly one result
    a_geom_single: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid_reg && job_reg.kind == wbmp_pkg::KIND_GEOMETRY) |-> (job_reg.cnt_m1 == 3'd0))
        else $error("geometry job with more than one result");

    // Row and image ends fall only on the last result of a byte
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (eor_reg || eoi_reg)) |-> last_reg)
        else $error("end flag on a result that is not last of its byte");

    // A new job is loaded only into a slot that is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        job_load |-> job_free)
        else $error("job loaded while slot busy");

endmodule

### design/wbmp_stream_decoder_top.sv
// WBMP type 0 decoder: one file byte per item in, geometry and pixel items out.
// Each accepted byte's results pass through the job register, then the output register.
// A byte is taken when the job slot is empty or its last item moves out; an image byte
// yields 1 to 8 items, drained one a cycle by the single output register unless stalled.
// Reset clears parser and handshake state; pixel values reset to 255 (set) and 0 (clear).
// Depends on wbmp_pkg, wbmp_parse and wbmp_emit.
`timescale 1ns / 1ps

module wbmp_stream_decoder_top #(
    parameter int DIM_BITS = wbmp_pkg::DIM_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [wbmp_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [7:0]                        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        byte_in,
    input  logic                              start_of_file,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              result_kind,
    output logic [7:0]                        pixel_value,
    output logic [15:0]                       pixel_column,
    output logic [15:0]                       pixel_row,
    output logic [15:0]                       image_width,
    output logic [15:0]                       image_height,
    output logic                              type_error,
    output logic                              last_of_run,
    output logic                              end_of_row,
    output logic                              end_of_image
);

    logic           job_free;
    logic           job_load;
    wbmp_pkg::job_t job;

    // Parse the byte stream into jobs
    wbmp_parse #(
        .DIM_BITS (DIM_BITS)
    ) u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .byte_in       (byte_in),
        .start_of_file (start_of_file),
        .job_free      (job_free),
        .job_load      (job_load),
        .job           (job)
    );

    // Expand jobs into result items
    wbmp_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .job_load     (job_load),
        .job          (job),
        .job_free     (job_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .pixel_value  (pixel_value),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .image_width  (image_width),
        .image_height (image_height),
        .type_error   (type_error),
        .last_of_run  (last_of_run),
        .end_of_row   (end_of_row),
        .end_of_image (end_of_image)
    );

endmodule
